[hw/rtl/ota_pkg.sv]
// Shared types, sizes and codes of the owner-tagged ID allocator.
`default_nettype none
package ota_pkg;

    localparam int FIRST_POOL_SLOTS  = 256;
    localparam int SECOND_POOL_SLOTS = 164;
    localparam int THIRD_POOL_SLOTS  = 64;
    localparam int OWNER_BITS        = 32;

    localparam int MAX_SLOTS_12 = (FIRST_POOL_SLOTS > SECOND_POOL_SLOTS) ?
                                  FIRST_POOL_SLOTS : SECOND_POOL_SLOTS;
    localparam int MAX_SLOTS    = (MAX_SLOTS_12 > THIRD_POOL_SLOTS) ?
                                  MAX_SLOTS_12 : THIRD_POOL_SLOTS;
    // Wide enough to hold the slot count itself.
    localparam int IDX_BITS     = $clog2(MAX_SLOTS + 1);

    localparam int FIRST_ADDR_BITS  = (FIRST_POOL_SLOTS > 1) ? $clog2(FIRST_POOL_SLOTS) : 1;
    localparam int SECOND_ADDR_BITS = (SECOND_POOL_SLOTS > 1) ? $clog2(SECOND_POOL_SLOTS) : 1;
    localparam int THIRD_ADDR_BITS  = (THIRD_POOL_SLOTS > 1) ? $clog2(THIRD_POOL_SLOTS) : 1;

    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_GONE    = 2'd2;

    localparam logic [1:0] POOL_FIRST  = 2'd0;
    localparam logic [1:0] POOL_SECOND = 2'd1;
    localparam logic [1:0] POOL_THIRD  = 2'd2;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_IGNORED   = 2'd2;
    localparam logic [1:0] ST_BAD_OWNER = 2'd3;

    typedef logic [OWNER_BITS-1:0] t_owner;

    typedef struct packed {
        logic [1:0]  op;
        logic [1:0]  pool;
        logic [7:0]  slot_id;
        logic [31:0] owner;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] granted_id;
    } t_out_word;

    // Port requests from the sequencer to the three slot memories.
    typedef struct packed {
        logic [2:0]          we;
        logic [IDX_BITS-1:0] rd_idx;
        logic [IDX_BITS-1:0] wr_idx;
        t_owner              wr_data;
    } t_ram_req;

    function automatic logic [IDX_BITS-1:0] pool_count(input logic [1:0] pool);
        logic [IDX_BITS-1:0] cnt;
        unique case (pool)
            POOL_FIRST:  cnt = IDX_BITS'(FIRST_POOL_SLOTS);
            POOL_SECOND: cnt = IDX_BITS'(SECOND_POOL_SLOTS);
            POOL_THIRD:  cnt = IDX_BITS'(THIRD_POOL_SLOTS);
            default:     cnt = '0;
        endcase
        return cnt;
    endfunction

    function automatic logic [2:0] pool_sel(input logic [1:0] pool);
        logic [2:0] sel;
        unique case (pool)
            POOL_FIRST:  sel = 3'b001;
            POOL_SECOND: sel = 3'b010;
            POOL_THIRD:  sel = 3'b100;
            default:     sel = 3'b000;
        endcase
        return sel;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/ota_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ota_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

[hw/rtl/ota_match.sv]
// Shared compare unit: selects one pool's read data and compares it with a key.
`default_nettype none
module ota_match (
    input  wire ota_pkg::t_owner i_data0,
    input  wire ota_pkg::t_owner i_data1,
    input  wire ota_pkg::t_owner i_data2,
    input  wire logic [1:0]      i_sel,
    input  wire ota_pkg::t_owner i_key,
    output logic                 o_hit
);
    import ota_pkg::*;

    always_comb begin
        unique case (i_sel)
            POOL_FIRST:  o_hit = (i_data0 == i_key);
            POOL_SECOND: o_hit = (i_data1 == i_key);
            POOL_THIRD:  o_hit = (i_data2 == i_key);
            default:     o_hit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

[hw/rtl/ota_seq.sv]
// Sequencer: clearing pass, slot scans, release check and the result register.
`default_nettype none
module ota_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ota_pkg::t_in_word i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ota_pkg::t_out_word     o_out,
    output ota_pkg::t_ram_req      o_req,
    output logic [1:0]             o_sel,
    output ota_pkg::t_owner        o_key,
    input  wire logic              i_hit
);
    import ota_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_RD    = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [IDX_BITS-1:0] r_idx, n_idx;
    logic [IDX_BITS-1:0] r_chk_idx, n_chk_idx;
    logic                r_chk_vld, n_chk_vld;
    logic [1:0]          r_op, n_op;
    logic [1:0]          r_pool, n_pool;
    t_owner              r_owner, n_owner;
    t_out_word           r_res, n_res;
    logic                r_out_vld, n_out_vld;
    t_out_word           r_out, n_out;

    logic [IDX_BITS-1:0] cnt;
    logic                issue;
    t_owner              in_owner;

    assign cnt      = pool_count(r_pool);
    assign issue    = (r_idx < cnt);
    assign in_owner = i_in.owner[OWNER_BITS-1:0];

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_chk_idx = r_chk_idx;
        n_chk_vld = r_chk_vld;
        n_op      = r_op;
        n_pool    = r_pool;
        n_owner   = r_owner;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;

        o_req.we      = 3'b000;
        o_req.rd_idx  = r_idx;
        o_req.wr_idx  = r_chk_idx;
        o_req.wr_data = (r_op == OP_ACQUIRE) ? r_owner : '0;

        if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_req.wr_idx  = r_idx;
                o_req.wr_data = '0;
                o_req.we[0]   = (r_idx < IDX_BITS'(FIRST_POOL_SLOTS));
                o_req.we[1]   = (r_idx < IDX_BITS'(SECOND_POOL_SLOTS));
                o_req.we[2]   = (r_idx < IDX_BITS'(THIRD_POOL_SLOTS));
                if (r_idx == IDX_BITS'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op      = i_in.op;
                    n_pool    = i_in.pool;
                    n_owner   = in_owner;
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    n_res     = '0;
                    n_state   = S_DONE;
                    if (in_owner == '0) begin
                        n_res.status = ST_BAD_OWNER;
                    end else begin
                        unique case (i_in.op)
                            OP_ACQUIRE: begin
                                if (pool_count(i_in.pool) == '0) begin
                                    n_res.status = ST_EXHAUSTED;
                                end else begin
                                    n_state = S_SCAN;
                                end
                            end
                            OP_RELEASE: begin
                                if ({1'b0, i_in.slot_id} <
                                    9'(pool_count(i_in.pool))) begin
                                    n_idx   = IDX_BITS'(i_in.slot_id);
                                    n_state = S_RD;
                                end else begin
                                    n_res.status = ST_IGNORED;
                                end
                            end
                            OP_GONE: begin
                                n_pool  = POOL_FIRST;
                                n_state = S_SCAN;
                            end
                            default: begin
                                n_res.status = ST_IGNORED;
                            end
                        endcase
                    end
                end
            end
            S_SCAN: begin
                // Reads run one slot ahead of the compare on the returned data.
                n_chk_vld = issue;
                n_chk_idx = r_idx;
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                end
                if (r_chk_vld && i_hit) begin
                    o_req.we = pool_sel(r_pool);
                end
                if (r_op == OP_ACQUIRE && r_chk_vld && i_hit) begin
                    n_res.status     = ST_DONE;
                    n_res.granted_id = 8'(r_chk_idx);
                    n_state          = S_DONE;
                end else if (!issue && !r_chk_vld) begin
                    if (r_op == OP_ACQUIRE) begin
                        n_res.status = ST_EXHAUSTED;
                        n_state      = S_DONE;
                    end else if (r_pool == POOL_THIRD) begin
                        n_res.status = ST_DONE;
                        n_state      = S_DONE;
                    end else begin
                        n_pool = r_pool + 1'b1;
                        n_idx  = '0;
                    end
                end
            end
            S_RD: begin
                n_state = S_CHK;
            end
            S_CHK: begin
                o_req.wr_idx = r_idx;
                if (i_hit) begin
                    o_req.we     = pool_sel(r_pool);
                    n_res.status = ST_DONE;
                end else begin
                    n_res.status = ST_IGNORED;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_chk_vld <= n_chk_vld;
            r_out_vld <= n_out_vld;
        end
        r_chk_idx <= n_chk_idx;
        r_op      <= n_op;
        r_pool    <= n_pool;
        r_owner   <= n_owner;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign o_sel       = r_pool;
    assign o_key       = (r_op == OP_ACQUIRE) ? '0 : r_owner;

endmodule
`default_nettype wire

[hw/rtl/owner_tagged_id_allocator.sv]
// Top level of the owner-tagged ID allocator: three slot memories, compare unit, sequencer.
//
// Input channel (i_in_valid / o_in_stall / i_in) carries one request word: acquire,
// release or owner gone, with pool, slot index and owner number. Output channel
// (o_out_valid / i_out_stall / o_out) returns one word per request: status and the
// granted slot index. A word moves at a clock edge with valid high and stall low.
// Each pool's owner table lives in a RAM with registered read; one comparator checks
// one slot per cycle, so work time is set by the number of slots visited.
// Acquire: slots are read from index 0 up to the lowest free slot, or through the whole
// pool when it is full. Release: only the named slot is read and checked. Owner gone:
// every slot of all three pools is read and matching ones freed.
// One request is in work at a time; o_in_stall is high until its result is loaded
// into the output register, and the next request may enter while that result waits.
// If the receiver stalls with a result still held, the finished request waits until
// the output register frees up.
// After reset the block clears all slot memories (one entry of each pool per cycle while
// that pool has entries left) with o_in_stall high; then every slot is free.
`default_nettype none
module owner_tagged_id_allocator (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ota_pkg::t_in_word i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ota_pkg::t_out_word     o_out
);
    import ota_pkg::*;

    t_ram_req   req;
    logic [1:0] sel;
    t_owner     key;
    logic       hit;
    t_owner     rd_data0, rd_data1, rd_data2;

    ota_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .o_req       (req),
        .o_sel       (sel),
        .o_key       (key),
        .i_hit       (hit)
    );

    ota_ram #(.WIDTH(OWNER_BITS), .DEPTH(FIRST_POOL_SLOTS)) u_ram_first (
        .i_clk     (i_clk),
        .i_we      (req.we[0]),
        .i_wr_addr (req.wr_idx[FIRST_ADDR_BITS-1:0]),
        .i_wr_data (req.wr_data),
        .i_rd_addr (req.rd_idx[FIRST_ADDR_BITS-1:0]),
        .o_rd_data (rd_data0)
    );

    ota_ram #(.WIDTH(OWNER_BITS), .DEPTH(SECOND_POOL_SLOTS)) u_ram_second (
        .i_clk     (i_clk),
        .i_we      (req.we[1]),
        .i_wr_addr (req.wr_idx[SECOND_ADDR_BITS-1:0]),
        .i_wr_data (req.wr_data),
        .i_rd_addr (req.rd_idx[SECOND_ADDR_BITS-1:0]),
        .o_rd_data (rd_data1)
    );

    ota_ram #(.WIDTH(OWNER_BITS), .DEPTH(THIRD_POOL_SLOTS)) u_ram_third (
        .i_clk     (i_clk),
        .i_we      (req.we[2]),
        .i_wr_addr (req.wr_idx[THIRD_ADDR_BITS-1:0]),
        .i_wr_data (req.wr_data),
        .i_rd_addr (req.rd_idx[THIRD_ADDR_BITS-1:0]),
        .o_rd_data (rd_data2)
    );

    ota_match u_match (
        .i_data0 (rd_data0),
        .i_data1 (rd_data1),
        .i_data2 (rd_data2),
        .i_sel   (sel),
        .i_key   (key),
        .o_hit   (hit)
    );

endmodule
`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the owner-tagged ID allocator, with its own slot-table predictor.
`timescale 1ns / 1ps
module tb;
    import ota_pkg::*;

    localparam logic [1:0] OP_NOP    = 2'd3;
    localparam logic [1:0] POOL_NONE = 2'd3;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int TAIL_CYCLES       = 20;
    localparam int OWNER_COUNT       = 8;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    t_in_word  i_in        = '0;
    logic      i_out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_word o_out;

    owner_tagged_id_allocator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted owner of every slot, updated when a request word is accepted.
    t_owner      owner_tab [3][MAX_SLOTS];
    t_out_word   pending_results[$];
    t_out_word   want;
    logic [31:0] owner_set [OWNER_COUNT];
    int          mismatches    = 0;
    int          idle_cycles   = 0;
    int          hold_request  = 0;
    bit          quiet         = 1'b0;

    function automatic int slots_in(input logic [1:0] p);
        case (p)
            POOL_FIRST:  return FIRST_POOL_SLOTS;
            POOL_SECOND: return SECOND_POOL_SLOTS;
            POOL_THIRD:  return THIRD_POOL_SLOTS;
            default:     return 0;
        endcase
    endfunction

    function automatic t_out_word apply_request(input t_in_word w);
        t_out_word r;
        t_owner    who;
        int        n;
        bit        found;
        r.status     = ST_IGNORED;
        r.granted_id = '0;
        who          = w.owner[OWNER_BITS-1:0];
        n            = slots_in(w.pool);
        found        = 1'b0;
        if (who == '0) begin
            r.status = ST_BAD_OWNER;
        end else begin
            case (w.op)
                OP_ACQUIRE: begin
                    r.status = ST_EXHAUSTED;
                    for (int i = 0; i < n; i++) begin
                        if (!found && owner_tab[w.pool][i] == '0) begin
                            owner_tab[w.pool][i] = who;
                            r.granted_id         = 8'(i);
                            r.status             = ST_DONE;
                            found                = 1'b1;
                        end
                    end
                end
                OP_RELEASE: begin
                    if (int'(w.slot_id) < n) begin
                        if (owner_tab[w.pool][w.slot_id] == who) begin
                            owner_tab[w.pool][w.slot_id] = '0;
                            r.status                     = ST_DONE;
                        end
                    end
                end
                OP_GONE: begin
                    for (int p = 0; p < 3; p++) begin
                        for (int i = 0; i < slots_in(2'(p)); i++) begin
                            if (owner_tab[p][i] == who) owner_tab[p][i] = '0;
                        end
                    end
                    r.status = ST_DONE;
                end
                default: r.status = ST_IGNORED;
            endcase
        end
        return r;
    endfunction

    function automatic int find_held(input logic [1:0] p, input int start);
        int n;
        int i;
        n = slots_in(p);
        for (int k = 0; k < n; k++) begin
            i = (start + k) % n;
            if (owner_tab[p][i] != '0) return i;
        end
        return -1;
    endfunction

    function automatic t_in_word make_word(input logic [1:0] op, input logic [1:0] pool,
                                           input logic [7:0] sid, input logic [31:0] who);
        t_in_word w;
        w.op      = op;
        w.pool    = pool;
        w.slot_id = sid;
        w.owner   = who;
        return w;
    endfunction

    function automatic logic [31:0] pick_owner();
        if ($urandom_range(0, 9) == 0) return $urandom();
        return owner_set[$urandom_range(0, OWNER_COUNT-1)];
    endfunction

    // Mostly short gaps, now and then a long one; none at all while quiet.
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        if (mismatches < 50)
            $display("%0t ns: %s: got %0d, expected %0d", $realtime, what, got, exp_v);
        mismatches++;
    endtask

    // Valid stays high from one word to the next when there is no gap.
    task automatic send_word(input t_in_word w);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(apply_request(w));
    endtask

    task automatic wait_for_results;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed;
        // Owner zero is refused whatever the operation.
        send_word(make_word(OP_ACQUIRE, POOL_FIRST, 8'h00, 32'h0));
        send_word(make_word(OP_RELEASE, POOL_FIRST, 8'h00, 32'h0));
        send_word(make_word(OP_GONE, POOL_SECOND, 8'h00, 32'h0));
        send_word(make_word(OP_NOP, POOL_NONE, 8'hFF, 32'h0));
        send_word(make_word(OP_ACQUIRE, POOL_FIRST, 8'hFF, 32'h1));
        send_word(make_word(OP_ACQUIRE, POOL_SECOND, 8'h00, 32'hFFFF_FFFF));
        send_word(make_word(OP_ACQUIRE, POOL_THIRD, 8'h00, 32'h8000_0000));
        send_word(make_word(OP_ACQUIRE, POOL_NONE, 8'h00, 32'h1));
        send_word(make_word(OP_ACQUIRE, POOL_FIRST, 8'h00, 32'h1));
        send_word(make_word(OP_RELEASE, POOL_FIRST, 8'h00, 32'h2));
        send_word(make_word(OP_RELEASE, POOL_FIRST, 8'h00, 32'h1));
        send_word(make_word(OP_RELEASE, POOL_FIRST, 8'h00, 32'h1));
        send_word(make_word(OP_RELEASE, POOL_FIRST, 8'hFF, 32'h1));
        send_word(make_word(OP_RELEASE, POOL_SECOND, 8'd164, 32'hFFFF_FFFF));
        send_word(make_word(OP_RELEASE, POOL_SECOND, 8'hFF, 32'hFFFF_FFFF));
        send_word(make_word(OP_RELEASE, POOL_THIRD, 8'h00, 32'h8000_0000));
        send_word(make_word(OP_RELEASE, POOL_NONE, 8'h00, 32'h1));
        send_word(make_word(OP_NOP, POOL_FIRST, 8'hFF, 32'hFFFF_FFFF));
        // An owner that holds nothing still gets a clean done.
        send_word(make_word(OP_GONE, POOL_FIRST, 8'h00, 32'h7));
        send_word(make_word(OP_GONE, POOL_NONE, 8'hFF, 32'h1));
        send_word(make_word(OP_ACQUIRE, POOL_FIRST, 8'h00, 32'h2));
        send_word(make_word(OP_GONE, POOL_SECOND, 8'h00, 32'hFFFF_FFFF));
        send_word(make_word(OP_GONE, POOL_THIRD, 8'h00, 32'h2));
        wait_for_results();
    endtask

    task automatic test_pool_exhaustion;
        logic [1:0] p;
        int         idx;
        for (int k = 0; k < 3; k++) begin
            p     = 2'(2 - k);
            quiet = (k == 2);
            for (int i = 0; i < slots_in(p); i++)
                send_word(make_word(OP_ACQUIRE, p, 8'($urandom_range(0, 255)),
                                    owner_set[$urandom_range(0, OWNER_COUNT-1)]));
            quiet = 1'b0;
            for (int j = 0; j < 2; j++)
                send_word(make_word(OP_ACQUIRE, p, 8'($urandom_range(0, 255)),
                                    owner_set[$urandom_range(0, OWNER_COUNT-1)]));
        end
        // Punch holes in the full pools; the lowest hole must be granted first.
        for (int k = 0; k < 3; k++) begin
            p = 2'(k);
            for (int j = 0; j < 5; j++) begin
                idx = find_held(p, $urandom_range(0, 255));
                send_word(make_word(OP_RELEASE, p, 8'(idx), owner_tab[p][idx]));
            end
            for (int j = 0; j < 5; j++)
                send_word(make_word(OP_ACQUIRE, p, 8'($urandom_range(0, 255)),
                                    owner_set[$urandom_range(0, OWNER_COUNT-1)]));
        end
        for (int i = 0; i < OWNER_COUNT; i++)
            send_word(make_word(OP_GONE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                owner_set[i]));
        wait_for_results();
    endtask

    task automatic test_backpressure;
        hold_request = 400;
        quiet        = 1'b1;
        for (int i = 0; i < 12; i++)
            send_word(make_word(OP_RELEASE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                pick_owner()));
        quiet = 1'b0;
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int count);
        t_in_word   w;
        int         r;
        int         idx;
        logic [1:0] p;
        for (int n = 0; n < count; n++) begin
            quiet = ((n % 300) >= 240);
            r     = $urandom_range(0, 99);
            p     = 2'($urandom_range(0, 2));
            if (r < 45) begin
                if ($urandom_range(0, 19) == 0) p = POOL_NONE;
                w = make_word(OP_ACQUIRE, p, 8'($urandom_range(0, 255)), pick_owner());
            end else if (r < 80) begin
                idx = find_held(p, $urandom_range(0, 255));
                if (idx >= 0)
                    w = make_word(OP_RELEASE, p, 8'(idx), owner_tab[p][idx]);
                else
                    w = make_word(OP_RELEASE, p, 8'($urandom_range(0, 255)), pick_owner());
            end else if (r < 86) begin
                w = make_word(OP_RELEASE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              pick_owner());
            end else if (r < 92) begin
                w = make_word(OP_GONE, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              pick_owner());
            end else if (r < 96) begin
                w = make_word(OP_NOP, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                              $urandom());
            end else begin
                w = make_word(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                              8'($urandom_range(0, 255)), 32'h0);
            end
            send_word(w);
        end
        quiet = 1'b0;
    endtask

    // Receiver side: random stall bursts, plus a long hold-off on request.
    initial begin : out_stall_gen
        int stall_left;
        int open_left;
        int hold_left;
        stall_left = 0;
        open_left  = 0;
        hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if (open_left > 0) begin
                open_left--;
                i_out_stall <= 1'b0;
            end else begin
                stall_left = pick_gap();
                open_left  = $urandom_range(0, 12);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with no request pending, status", o_out.status, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out.status !== want.status)
                    report_mismatch("status", o_out.status, want.status);
                if (o_out.granted_id !== want.granted_id)
                    report_mismatch("granted_id", o_out.granted_id, want.granted_id);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        for (int p = 0; p < 3; p++)
            for (int i = 0; i < MAX_SLOTS; i++)
                owner_tab[p][i] = '0;
        owner_set[0] = 32'h1;
        owner_set[1] = 32'hFFFF_FFFF;
        owner_set[2] = 32'h8000_0000;
        for (int i = 3; i < OWNER_COUNT; i++)
            owner_set[i] = $urandom() | 32'h1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_pool_exhaustion();
        test_backpressure();
        test_random_traffic(1340);
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
